>>> rtl/twsb_pkg.sv
// Shared types and constants for the two-wire sensor bus master.
// No dependencies; imported by every module of the block.
`default_nettype none

package twsb_pkg;

  typedef enum logic [8:0] {
    STEP_IDLE  = 9'b000000001,
    STEP_CRST  = 9'b000000010,
    STEP_START = 9'b000000100,
    STEP_WCMD  = 9'b000001000,
    STEP_WVAL  = 9'b000010000,
    STEP_WAIT  = 9'b000100000,
    STEP_RB0   = 9'b001000000,
    STEP_RB1   = 9'b010000000,
    STEP_RB2   = 9'b100000000
  } step_e;

  localparam logic [2:0] CMD_TEMP     = 3'd0;
  localparam logic [2:0] CMD_HUMI     = 3'd1;
  localparam logic [2:0] CMD_RD_STAT  = 3'd2;
  localparam logic [2:0] CMD_WR_STAT  = 3'd3;
  localparam logic [2:0] CMD_SOFT_RST = 3'd4;
  localparam logic [2:0] CMD_CONN_RST = 3'd5;

  localparam logic [15:0] POLL_RESET = 16'd500;

  // transmission start pattern, indexed by phase
  localparam logic [6:0] START_SCK = 7'b0110110;
  localparam logic [6:0] START_SDA = 7'b1100011;

  typedef struct packed {
    logic [7:0]  checksum;
    logic [15:0] read_value;
    logic [1:0]  error_count;
    logic        done_res;
    logic        busy_res;
    logic        sda_release;
    logic        sck_out;
  } res_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
    logic [7:0] code;
    unique case (cmd)
      CMD_TEMP:     code = 8'h03;
      CMD_HUMI:     code = 8'h05;
      CMD_RD_STAT:  code = 8'h07;
      CMD_WR_STAT:  code = 8'h06;
      CMD_SOFT_RST: code = 8'h1e;
      default:      code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/twsb_core.sv
// Sequencer of the bus master: state registers and one-tick update logic.
// Depends on twsb_pkg.
`default_nettype none

module twsb_core
  import twsb_pkg::*;
#(
  parameter int RESET_CLOCKS = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        fire_i,
  input  wire logic        op_i,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  write_value_i,
  input  wire logic        sda_in_i,
  output res_t             res_o
);

  localparam logic [3:0] RST_LAST = 4'(RESET_CLOCKS - 1);

  step_e       step_q, step_d, enter_tgt;
  logic [2:0]  phase_q, phase_d, p_sel;
  logic [3:0]  bidx_q, bidx_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] poll_q, poll_d, poll_int_q;
  logic [15:0] value_q, value_d;
  logic [7:0]  check_q, check_d;
  logic [1:0]  err_q, err_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [7:0]  wr_q, wr_d;
  logic        adv, enter_en, fin, meas, ack, sck, sda;

  always_comb begin
    step_d    = step_q;
    phase_d   = phase_q;
    bidx_d    = bidx_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    value_d   = value_q;
    check_d   = check_q;
    err_d     = err_q;
    cmd_d     = cmd_q;
    wr_d      = wr_q;
    adv       = 1'b0;
    enter_en  = 1'b0;
    enter_tgt = STEP_IDLE;
    fin       = 1'b0;
    sck       = 1'b0;
    sda       = 1'b1;
    p_sel     = 3'd0;
    ack       = 1'b0;

    // start request, taken only while idle
    if (step_q == STEP_IDLE && op_i && command_i <= CMD_CONN_RST) begin
      cmd_d   = command_i;
      wr_d    = write_value_i;
      value_d = '0;
      check_d = '0;
      err_d   = '0;
      step_d  = (command_i >= CMD_SOFT_RST) ? STEP_CRST : STEP_START;
      phase_d = '0;
      bidx_d  = '0;
      poll_d  = '0;
      shift_d = '0;
    end
    meas = (cmd_d <= CMD_HUMI);

    unique case (step_d)
      STEP_CRST: begin
        if (phase_d == 3'd0) begin
          sck     = 1'b1;
          phase_d = 3'd1;
        end else begin
          phase_d = 3'd0;
          if (bidx_d >= RST_LAST) adv = 1'b1;
          else bidx_d = bidx_d + 4'd1;
        end
      end
      STEP_START: begin
        p_sel = (phase_d == 3'd7) ? 3'd6 : phase_d;
        sck   = START_SCK[p_sel];
        sda   = START_SDA[p_sel];
        if (p_sel == 3'd6) adv = 1'b1;
        else phase_d = p_sel + 3'd1;
      end
      STEP_WCMD, STEP_WVAL: begin
        if (bidx_d < 4'd8) begin
          sda = shift_d[7];
          if (phase_d == 3'd0) phase_d = 3'd1;
          else begin
            sck     = 1'b1;
            phase_d = 3'd0;
            shift_d = {shift_d[6:0], 1'b0};
            bidx_d  = bidx_d + 4'd1;
          end
        end else if (phase_d == 3'd0) phase_d = 3'd1;
        else if (phase_d == 3'd1) begin
          sck = 1'b1;
          if (sda_in_i && err_d != 2'd3) err_d = err_d + 2'd1;
          phase_d = 3'd2;
        end else adv = 1'b1;
      end
      STEP_WAIT: begin
        poll_d = poll_d + 16'd1;
        if (poll_d >= poll_int_q) begin
          poll_d = '0;
          if (!sda_in_i) adv = 1'b1;
        end
      end
      STEP_RB0, STEP_RB1, STEP_RB2: begin
        ack = (step_d == STEP_RB0) || (step_d == STEP_RB1 && meas);
        if (bidx_d < 4'd8) begin
          if (phase_d == 3'd0) phase_d = 3'd1;
          else begin
            sck     = 1'b1;
            phase_d = 3'd0;
            shift_d = {shift_d[6:0], sda_in_i};
            bidx_d  = bidx_d + 4'd1;
          end
        end else if (phase_d == 3'd0) begin
          sda     = !ack;
          phase_d = 3'd1;
        end else if (phase_d == 3'd1) begin
          sck     = 1'b1;
          sda     = !ack;
          phase_d = 3'd2;
        end else adv = 1'b1;
      end
      default: ;
    endcase

    if (adv) begin
      unique case (step_d)
        STEP_CRST: begin
          enter_en  = 1'b1;
          enter_tgt = STEP_START;
        end
        STEP_START: begin
          if (cmd_d == CMD_CONN_RST) fin = 1'b1;
          else begin
            enter_en  = 1'b1;
            enter_tgt = STEP_WCMD;
          end
        end
        STEP_WCMD: begin
          priority if (meas) begin
            if (err_d != 2'd0) fin = 1'b1;
            else begin
              enter_en  = 1'b1;
              enter_tgt = STEP_WAIT;
            end
          end else if (cmd_d == CMD_RD_STAT) begin
            enter_en  = 1'b1;
            enter_tgt = STEP_RB0;
          end else if (cmd_d == CMD_WR_STAT) begin
            enter_en  = 1'b1;
            enter_tgt = STEP_WVAL;
          end else fin = 1'b1;
        end
        STEP_WAIT: begin
          enter_en  = 1'b1;
          enter_tgt = STEP_RB0;
        end
        STEP_RB0: begin
          value_d   = meas ? {shift_d, 8'h00} : {8'h00, shift_d};
          enter_en  = 1'b1;
          enter_tgt = STEP_RB1;
        end
        STEP_RB1: begin
          if (meas) begin
            value_d   = {value_d[15:8], value_d[7:0] | shift_d};
            enter_en  = 1'b1;
            enter_tgt = STEP_RB2;
          end else begin
            check_d = shift_d;
            fin     = 1'b1;
          end
        end
        default: begin
          if (step_d == STEP_RB2) check_d = shift_d;
          fin = 1'b1;
        end
      endcase
    end

    if (enter_en) begin
      step_d  = enter_tgt;
      phase_d = '0;
      bidx_d  = '0;
      poll_d  = '0;
      if (enter_tgt == STEP_WCMD) shift_d = cmd_code(cmd_d);
      else if (enter_tgt == STEP_WVAL) shift_d = wr_d;
      else shift_d = '0;
    end
    if (fin) begin
      step_d  = STEP_IDLE;
      phase_d = '0;
      bidx_d  = '0;
    end

    res_o.sck_out     = sck;
    res_o.sda_release = sda;
    res_o.busy_res    = (step_d != STEP_IDLE);
    res_o.done_res    = fin;
    res_o.error_count = err_d;
    res_o.read_value  = value_d;
    res_o.checksum    = check_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_IDLE;
      phase_q    <= '0;
      bidx_q     <= '0;
      shift_q    <= '0;
      poll_q     <= '0;
      value_q    <= '0;
      check_q    <= '0;
      err_q      <= '0;
      cmd_q      <= '0;
      wr_q       <= '0;
      poll_int_q <= POLL_RESET;
    end else begin
      if (cfg_valid_i) poll_int_q <= cfg_data_i;
      if (fire_i) begin
        step_q  <= step_d;
        phase_q <= phase_d;
        bidx_q  <= bidx_d;
        shift_q <= shift_d;
        poll_q  <= poll_d;
        value_q <= value_d;
        check_q <= check_d;
        err_q   <= err_d;
        cmd_q   <= cmd_d;
        wr_q    <= wr_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/twsb_skid.sv
// Two-entry result buffer: output register plus skid register.
// Depends on twsb_pkg for the result type.
`default_nettype none

module twsb_skid
  import twsb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire res_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  res_t out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign pop         = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    priority if (pop && skid_valid_q) begin
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else if (push && out_valid_q && !pop) begin
      skid_data_d  = in_data_i;
      skid_valid_d = 1'b1;
    end else if (push) begin
      out_data_d  = in_data_i;
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

`default_nettype wire

>>> rtl/two_wire_sensor_bus_master_top.sv
// Top level of the two-wire sensor bus master.
// Depends on twsb_pkg, twsb_core and twsb_skid.
//
// Usage: each request on the s_axis channel is one bus half-phase tick with
// the sampled data pin; tuser set with a command in tdata starts a sequence
// when the master is idle. Every request yields exactly one result on m_axis
// with the pin levels for that tick, busy/done, ack error count, read data
// and checksum. The poll interval register is written on the cfg channel,
// which is always ready; the user must write it only while the bus is idle, as
// the block itself does not enforce this. Throughput: one request per cycle while
// s_axis_tready is high; the sequencer updates its state in the cycle it takes
// a request and the result is held in an output register.
// Reset: the sequencer returns to idle and its read value, checksum and error
// count clear to zero; the result buffer empties; the poll interval returns to 500.
// Stall: a two-entry result buffer absorbs one more request while the
// receiver holds off; s_axis_tready drops once both entries are full.
`default_nettype none

module two_wire_sensor_bus_master_top
  import twsb_pkg::*;
#(
  parameter int RESET_CLOCKS = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,      // poll_interval
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,    // command[2:0], write_value[10:3], sda_in[11]
  input  wire logic        s_axis_tuser,    // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata     // sck_out, sda_release, busy_res, done_res,
                                            // error_count, read_value, checksum
);

  logic fire;
  res_t core_res, out_res;

  assign cfg_ready_o = 1'b1;
  assign fire        = s_axis_tvalid && s_axis_tready;

  twsb_core #(
    .RESET_CLOCKS(RESET_CLOCKS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .op_i         (s_axis_tuser),
    .command_i    (s_axis_tdata[2:0]),
    .write_value_i(s_axis_tdata[10:3]),
    .sda_in_i     (s_axis_tdata[11]),
    .res_o        (core_res)
  );

  twsb_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (core_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.checksum, out_res.read_value, out_res.error_count,
                         out_res.done_res, out_res.busy_res, out_res.sda_release,
                         out_res.sck_out};

endmodule

`default_nettype wire
